[design/assert_macros.svh]
// assertion macros used by the checker file
// needs a clock named clk and a reset named rst in the using scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define SVM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("svm assertion failed");

// antecedent implies consequent in the following cycle
`define SVM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("svm assertion failed");

`endif

[design/svm_pkg.sv]
// shared types and constants of the stack machine execute block
// used by every module of the block, no dependencies
package svm_pkg;

  localparam int STACK_DEPTH = 256;
  localparam int STACK_AW    = $clog2(STACK_DEPTH);
  localparam int NUM_REGS    = 12;
  localparam int REG_AW      = 4;
  localparam int WORD_W      = 32;
  localparam int DIV_CNT_W   = $clog2(WORD_W);

  // stack pointer value when the top entry is the last one
  localparam logic signed [WORD_W-1:0] SP_TOP = WORD_W'(STACK_DEPTH - 1);

  localparam logic [REG_AW-1:0] REG_A  = 4'd0;
  localparam logic [REG_AW-1:0] REG_B  = 4'd1;
  localparam logic [REG_AW-1:0] REG_C  = 4'd2;
  localparam logic [REG_AW-1:0] REG_IP = 4'd10;
  localparam logic [REG_AW-1:0] REG_SP = 4'd11;

  // opcodes
  localparam logic [3:0] OP_HLT = 4'd0;
  localparam logic [3:0] OP_PSH = 4'd1;
  localparam logic [3:0] OP_POP = 4'd2;
  localparam logic [3:0] OP_ADD = 4'd3;
  localparam logic [3:0] OP_MUL = 4'd4;
  localparam logic [3:0] OP_DIV = 4'd5;
  localparam logic [3:0] OP_SUB = 4'd6;
  localparam logic [3:0] OP_MOV = 4'd7;
  localparam logic [3:0] OP_SET = 4'd8;
  localparam logic [3:0] OP_LOG = 4'd9;
  localparam logic [3:0] OP_NOP = 4'd10;

  // result kinds
  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_LOG   = 2'd1;
  localparam logic [1:0] KIND_ARITH = 2'd2;

  // status codes
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_BADOP  = 3'd1;
  localparam logic [2:0] ST_DIVZ   = 3'd2;
  localparam logic [2:0] ST_OVF    = 3'd3;
  localparam logic [2:0] ST_UNF    = 3'd4;
  localparam logic [2:0] ST_BADREG = 3'd5;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic commit_simple;
    logic rd_top;
    logic rd_next;
    logic take_b;
    logic div_start;
    logic commit_arith;
    logic out_load;
  } svm_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic arith_go;
    logic is_div;
    logic a_zero;
    logic div_busy;
  } svm_sts_t;

endpackage

[design/svm_div.sv]
// iterative unsigned 32-bit divider, one quotient bit per cycle
// depends on svm_pkg
module svm_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [svm_pkg::WORD_W-1:0]   num,
  input  logic [svm_pkg::WORD_W-1:0]   den,
  output logic                         busy,
  output logic [svm_pkg::WORD_W-1:0]   quo
);

  logic [svm_pkg::WORD_W-1:0]    rem;
  logic [svm_pkg::WORD_W-1:0]    dsr;
  logic [svm_pkg::DIV_CNT_W-1:0] cnt;
  logic [svm_pkg::WORD_W:0]      trial;

  // trial subtract of the shifted remainder
  assign trial = {rem, quo[svm_pkg::WORD_W-1]} - {1'b0, dsr};

  // busy flag and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == {svm_pkg::DIV_CNT_W{1'b1}}) begin
        busy <= 1'b0;
      end
    end
  end

  // restoring division datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= num;
      dsr <= den;
    end else if (busy) begin
      if (!trial[svm_pkg::WORD_W]) begin
        rem <= trial[svm_pkg::WORD_W-1:0];
        quo <= {quo[svm_pkg::WORD_W-2:0], 1'b1};
      end else begin
        rem <= {rem[svm_pkg::WORD_W-2:0], quo[svm_pkg::WORD_W-1]};
        quo <= {quo[svm_pkg::WORD_W-2:0], 1'b0};
      end
    end
  end

endmodule

[design/svm_ctrl.sv]
// controller state machine for the stack machine execute block
// depends on svm_pkg, drives svm_dpath through svm_cmd_t
module svm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  svm_pkg::svm_sts_t sts,
  output svm_pkg::svm_cmd_t cmd
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DECODE = 7'b0000010,
    S_RDA    = 7'b0000100,
    S_RDB    = 7'b0001000,
    S_DIV    = 7'b0010000,
    S_CALC   = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic   slot_free;

  assign in_ready  = (state == S_IDLE);
  assign slot_free = !out_valid || out_ready;

  // next state and command decode
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.arith_go) begin
          cmd.rd_top = 1'b1;
          state_next = S_RDA;
        end else begin
          cmd.commit_simple = 1'b1;
          state_next        = S_DONE;
        end
      end
      S_RDA: begin
        cmd.rd_next = 1'b1;
        state_next  = S_RDB;
      end
      S_RDB: begin
        cmd.take_b = 1'b1;
        if (sts.is_div && !sts.a_zero) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end else begin
          state_next = S_CALC;
        end
      end
      S_DIV: begin
        if (!sts.div_busy) begin
          state_next = S_CALC;
        end
      end
      S_CALC: begin
        cmd.commit_arith = 1'b1;
        state_next       = S_DONE;
      end
      S_DONE: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state and output valid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[design/svm_dpath.sv]
// datapath: register file, data stack memory, alu and result registers
// depends on svm_pkg and svm_div, commanded by svm_ctrl
module svm_dpath (
  input  logic                     clk,
  input  logic                     rst,
  input  svm_pkg::svm_cmd_t        cmd,
  output svm_pkg::svm_sts_t        sts,
  input  logic [3:0]               operation,
  input  logic signed [31:0]       first_operand,
  input  logic signed [31:0]       second_operand,
  output logic signed [31:0]       result_value,
  output logic [1:0]               result_kind,
  output logic                     halted,
  output logic signed [31:0]       next_ip,
  output logic [2:0]               status
);

  // latched request
  logic [3:0]  op;
  logic [31:0] fo;
  logic [31:0] so;

  // architectural state
  logic [31:0] regs [svm_pkg::NUM_REGS];
  logic        halt_flag;

  // stack memory with per-entry written bits
  logic [31:0]                    stk_mem [svm_pkg::STACK_DEPTH];
  logic [svm_pkg::STACK_DEPTH-1:0] stk_vld;
  logic [31:0]                    stk_rdata;
  logic                           stk_rvld;
  logic                           stk_re;
  logic [svm_pkg::STACK_AW-1:0]   stk_raddr;
  logic [svm_pkg::STACK_AW-1:0]   stk_waddr;
  logic [31:0]                    stk_wdata;
  logic                           stk_we;
  logic [31:0]                    stk_q;

  // operands and results
  logic [31:0] a_reg, b_reg;
  logic [31:0] c_val;
  logic [31:0] prod;
  logic [31:0] quo;
  logic        div_busy;
  logic        q_neg;

  // pending result
  logic [31:0] pend_value;
  logic [1:0]  pend_kind;
  logic        pend_halted;
  logic [31:0] pend_ip;
  logic [2:0]  pend_status;

  // decode
  logic signed [31:0]        sp;
  logic [31:0]               ip;
  logic                      f_ok, s_ok;
  logic [svm_pkg::REG_AW-1:0] f_idx, s_idx;
  logic                      is_arith;
  logic [2:0]                st_dec;
  logic [1:0]                words;
  logic [31:0]               ip_base;
  logic [31:0]               ip_new;
  logic [31:0]               sp_inc, sp_dec;

  assign sp     = regs[svm_pkg::REG_SP];
  assign ip     = regs[svm_pkg::REG_IP];
  assign sp_inc = sp + 32'sd1;
  assign sp_dec = sp - 32'sd1;
  assign f_ok   = fo < 32'(svm_pkg::NUM_REGS);
  assign s_ok   = so < 32'(svm_pkg::NUM_REGS);
  assign f_idx  = fo[svm_pkg::REG_AW-1:0];
  assign s_idx  = so[svm_pkg::REG_AW-1:0];
  assign is_arith = (op == svm_pkg::OP_ADD) || (op == svm_pkg::OP_MUL) ||
                    (op == svm_pkg::OP_DIV) || (op == svm_pkg::OP_SUB);

  // status and operand word count per opcode
  always_comb begin
    st_dec = svm_pkg::ST_OK;
    words  = 2'd0;
    unique case (op)
      svm_pkg::OP_HLT, svm_pkg::OP_NOP: ;
      svm_pkg::OP_PSH: begin
        words = 2'd1;
        if (sp >= svm_pkg::SP_TOP) st_dec = svm_pkg::ST_OVF;
        else if (sp < -32'sd1) st_dec = svm_pkg::ST_UNF;
      end
      svm_pkg::OP_POP: begin
        if (sp <= -32'sd1) st_dec = svm_pkg::ST_UNF;
        else if (sp > svm_pkg::SP_TOP) st_dec = svm_pkg::ST_OVF;
      end
      svm_pkg::OP_ADD, svm_pkg::OP_MUL, svm_pkg::OP_DIV, svm_pkg::OP_SUB: begin
        if (sp < 32'sd1) st_dec = svm_pkg::ST_UNF;
        else if (sp > svm_pkg::SP_TOP) st_dec = svm_pkg::ST_OVF;
      end
      svm_pkg::OP_MOV: begin
        words = 2'd2;
        if (!(f_ok && s_ok)) st_dec = svm_pkg::ST_BADREG;
      end
      svm_pkg::OP_SET: begin
        words = 2'd2;
        if (!f_ok) st_dec = svm_pkg::ST_BADREG;
      end
      svm_pkg::OP_LOG: begin
        words = 2'd1;
        if (!f_ok) st_dec = svm_pkg::ST_BADREG;
      end
      default: st_dec = svm_pkg::ST_BADOP;
    endcase
  end

  // ip after a possible write by mov or set
  always_comb begin
    ip_base = ip;
    if (st_dec == svm_pkg::ST_OK) begin
      if (op == svm_pkg::OP_MOV && s_idx == svm_pkg::REG_IP) ip_base = regs[f_idx];
      else if (op == svm_pkg::OP_SET && f_idx == svm_pkg::REG_IP) ip_base = so;
    end
  end
  assign ip_new = ip_base + 32'(words) + 32'd1;

  // status to the controller
  assign sts.arith_go = is_arith && (st_dec == svm_pkg::ST_OK) && !halt_flag;
  assign sts.is_div   = (op == svm_pkg::OP_DIV);
  assign sts.a_zero   = (a_reg == 32'd0);
  assign sts.div_busy = div_busy;

  // request latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= operation;
      fo <= first_operand;
      so <= second_operand;
    end
  end

  // stack port control
  assign stk_re    = cmd.rd_top || cmd.rd_next;
  assign stk_raddr = cmd.rd_next ? sp_dec[svm_pkg::STACK_AW-1:0]
                                 : sp[svm_pkg::STACK_AW-1:0];
  assign stk_we    = (cmd.commit_simple && !halt_flag && op == svm_pkg::OP_PSH &&
                      st_dec == svm_pkg::ST_OK) || cmd.commit_arith;
  assign stk_waddr = cmd.commit_arith ? sp_dec[svm_pkg::STACK_AW-1:0]
                                      : sp_inc[svm_pkg::STACK_AW-1:0];
  assign stk_wdata = cmd.commit_arith ? c_val : fo;
  assign stk_q     = stk_rvld ? stk_rdata : 32'd0;

  // stack memory, read data held between reads
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    if (stk_re) begin
      stk_rdata <= stk_mem[stk_raddr];
    end
  end

  // written bits, an unwritten entry reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      stk_vld  <= '0;
      stk_rvld <= 1'b0;
    end else begin
      if (stk_we) begin
        stk_vld[stk_waddr] <= 1'b1;
      end
      if (stk_re) begin
        stk_rvld <= stk_vld[stk_raddr];
      end
    end
  end

  // operand capture
  always_ff @(posedge clk) begin
    if (cmd.rd_next) a_reg <= stk_q;
    if (cmd.take_b)  b_reg <= stk_q;
    if (cmd.take_b)  q_neg <= stk_q[31] ^ a_reg[31];
  end

  svm_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (stk_q[31] ? 32'd0 - stk_q : stk_q),
    .den   (a_reg[31] ? 32'd0 - a_reg : a_reg),
    .busy  (div_busy),
    .quo   (quo)
  );

  // arithmetic result
  assign prod = b_reg * a_reg;
  always_comb begin
    unique case (op)
      svm_pkg::OP_ADD: c_val = b_reg + a_reg;
      svm_pkg::OP_SUB: c_val = b_reg - a_reg;
      svm_pkg::OP_MUL: c_val = prod;
      default:         c_val = (a_reg == 32'd0) ? 32'd0 : (q_neg ? 32'd0 - quo : quo);
    endcase
  end

  // register file and halt flag
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < svm_pkg::NUM_REGS; i++) begin
        regs[i] <= '0;
      end
      regs[svm_pkg::REG_SP] <= '1;
      halt_flag <= 1'b0;
    end else if (cmd.commit_simple && !halt_flag) begin
      if (st_dec == svm_pkg::ST_OK) begin
        unique case (op)
          svm_pkg::OP_HLT: halt_flag <= 1'b1;
          svm_pkg::OP_PSH: regs[svm_pkg::REG_SP] <= sp_inc;
          svm_pkg::OP_POP: regs[svm_pkg::REG_SP] <= sp_dec;
          svm_pkg::OP_MOV: regs[s_idx] <= regs[f_idx];
          svm_pkg::OP_SET: regs[f_idx] <= so;
          default: ;
        endcase
      end
      regs[svm_pkg::REG_IP] <= ip_new;
    end else if (cmd.commit_arith) begin
      regs[svm_pkg::REG_A]  <= a_reg;
      regs[svm_pkg::REG_B]  <= b_reg;
      regs[svm_pkg::REG_C]  <= c_val;
      regs[svm_pkg::REG_SP] <= sp_dec;
      regs[svm_pkg::REG_IP] <= ip + 32'd1;
    end
  end

  // pending result
  always_ff @(posedge clk) begin
    if (cmd.commit_simple) begin
      pend_value  <= '0;
      pend_kind   <= svm_pkg::KIND_NONE;
      pend_halted <= halt_flag || (op == svm_pkg::OP_HLT);
      pend_ip     <= halt_flag ? ip : ip_new;
      pend_status <= halt_flag ? svm_pkg::ST_OK : st_dec;
      if (!halt_flag && op == svm_pkg::OP_LOG && st_dec == svm_pkg::ST_OK) begin
        pend_value <= regs[f_idx];
        pend_kind  <= svm_pkg::KIND_LOG;
      end
    end else if (cmd.commit_arith) begin
      pend_value  <= c_val;
      pend_kind   <= svm_pkg::KIND_ARITH;
      pend_halted <= 1'b0;
      pend_ip     <= ip + 32'd1;
      pend_status <= (op == svm_pkg::OP_DIV && a_reg == 32'd0) ? svm_pkg::ST_DIVZ
                                                              : svm_pkg::ST_OK;
    end
  end

  // output registers
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result_value <= pend_value;
      result_kind  <= pend_kind;
      halted       <= pend_halted;
      next_ip      <= pend_ip;
      status       <= pend_status;
    end
  end

endmodule

[design/stack_register_vm_execute.sv]
// Stack machine execute block, top level.
// Input channel in_valid/in_ready carries one decoded instruction per request:
// operation, first_operand, second_operand. Output channel out_valid/out_ready
// returns one result per request: result_value, result_kind, halted, next_ip
// and status. The block works on one request at a time; in_ready is high only
// while no request is in flight.
// Push, pop, mov, set, log, nop, halt and flagged errors go from decode straight
// to done; add, sub, mul and div first read two entries through the single read
// port of the stack memory, and a divide then waits for the one-bit-per-cycle
// divider (32 steps). A divide by zero skips the divider. Reset clears the
// register file (stack pointer to -1), the halt flag and the per-entry written
// bits of the 256-entry stack, so the stack reads as zero.
// A result waits in the output register while the receiver stalls; the next
// request is still accepted and runs until its own result is ready.
// Depends on svm_pkg, svm_ctrl, svm_dpath and svm_div.
module stack_register_vm_execute (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         operation,
  input  logic signed [31:0] first_operand,
  input  logic signed [31:0] second_operand,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] result_value,
  output logic [1:0]         result_kind,
  output logic               halted,
  output logic signed [31:0] next_ip,
  output logic [2:0]         status
);

  svm_pkg::svm_cmd_t cmd;
  svm_pkg::svm_sts_t sts;

  // controller
  svm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath
  svm_dpath u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .operation      (operation),
    .first_operand  (first_operand),
    .second_operand (second_operand),
    .result_value   (result_value),
    .result_kind    (result_kind),
    .halted         (halted),
    .next_ip        (next_ip),
    .status         (status)
  );

endmodule

[design/svm_checker.sv]
// port-level checks of the stack machine execute block, bound to the top
// depends on svm_pkg and assert_macros.svh
`include "assert_macros.svh"

module svm_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic [3:0]         operation,
  input logic signed [31:0] first_operand,
  input logic signed [31:0] second_operand,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] result_value,
  input logic [1:0]         result_kind,
  input logic               halted,
  input logic signed [31:0] next_ip,
  input logic [2:0]         status
);

  // stalled result holds
  `SVM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(result_value) && $stable(next_ip))

  // one request in flight at a time
  `SVM_ASSERT_NEXT(a_one_inflight, in_valid && in_ready, !in_ready)

  // halted results carry nothing
  `SVM_ASSERT_NOW(a_halt_quiet, out_valid && halted, result_kind == svm_pkg::KIND_NONE && status == svm_pkg::ST_OK)

  // flagged errors other than divide by zero produce no value
  `SVM_ASSERT_NOW(a_err_quiet, out_valid && status != svm_pkg::ST_OK && status != svm_pkg::ST_DIVZ, result_kind == svm_pkg::KIND_NONE)

endmodule

bind stack_register_vm_execute svm_checker u_svm_checker (.*);

[tb/tb.sv]
// testbench for stack_register_vm_execute: random and directed instruction streams
// a scoreboard class predicts every result from its own copy of registers and stack
// depends on svm_pkg and the rtl of the execute block
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [31:0] value;
    logic [1:0]         kind;
    logic               hlt;
    logic signed [31:0] ip;
    logic [2:0]         st;
  } vm_result_t;

  // predictor of the execute stage plus the queue of expected results
  class vm_scoreboard;
    logic [31:0] regs [svm_pkg::NUM_REGS];
    logic [31:0] stack_mem [svm_pkg::STACK_DEPTH];
    bit          stopped;
    vm_result_t  pending [$];
    int          errors;

    function void clear();
      foreach (regs[i]) regs[i] = '0;
      regs[svm_pkg::REG_SP] = '1;
      foreach (stack_mem[i]) stack_mem[i] = '0;
      stopped = 0;
    endfunction

    function logic [31:0] divide(logic [31:0] num, logic [31:0] den);
      logic [31:0] un, ud, q;
      un = num[31] ? -num : num;
      ud = den[31] ? -den : den;
      q = un / ud;
      return (num[31] != den[31]) ? -q : q;
    endfunction

    // note an accepted request and compute its expected result
    function void note_request(logic [3:0] op, logic [31:0] f, logic [31:0] s);
      vm_result_t r;
      longint depth;
      logic [31:0] a, b, c;
      int words;
      r = '{0, svm_pkg::KIND_NONE, 1'b0, 0, svm_pkg::ST_OK};
      words = 0;
      depth = longint'($signed(regs[svm_pkg::REG_SP])) + 1;
      if (stopped) begin
        r.hlt = 1;
        r.ip = regs[svm_pkg::REG_IP];
        pending.push_back(r);
        return;
      end
      case (op)
        svm_pkg::OP_HLT: stopped = 1;
        svm_pkg::OP_PSH: begin
          words = 1;
          if (depth >= svm_pkg::STACK_DEPTH) r.st = svm_pkg::ST_OVF;
          else if (depth < 0) r.st = svm_pkg::ST_UNF;
          else begin
            stack_mem[depth] = f;
            regs[svm_pkg::REG_SP] = depth;
          end
        end
        svm_pkg::OP_POP: begin
          if (depth <= 0) r.st = svm_pkg::ST_UNF;
          else if (depth > svm_pkg::STACK_DEPTH) r.st = svm_pkg::ST_OVF;
          else regs[svm_pkg::REG_SP] = depth - 2;
        end
        svm_pkg::OP_ADD, svm_pkg::OP_MUL, svm_pkg::OP_DIV, svm_pkg::OP_SUB: begin
          if (depth < 2) r.st = svm_pkg::ST_UNF;
          else if (depth > svm_pkg::STACK_DEPTH) r.st = svm_pkg::ST_OVF;
          else begin
            a = stack_mem[depth-1];
            b = stack_mem[depth-2];
            if (op == svm_pkg::OP_ADD) c = b + a;
            else if (op == svm_pkg::OP_MUL) c = b * a;
            else if (op == svm_pkg::OP_SUB) c = b - a;
            else if (a == 0) begin
              c = 0;
              r.st = svm_pkg::ST_DIVZ;
            end else c = divide(b, a);
            regs[svm_pkg::REG_A] = a;
            regs[svm_pkg::REG_B] = b;
            regs[svm_pkg::REG_C] = c;
            stack_mem[depth-2] = c;
            regs[svm_pkg::REG_SP] = depth - 2;
            r.value = c;
            r.kind = svm_pkg::KIND_ARITH;
          end
        end
        svm_pkg::OP_MOV: begin
          words = 2;
          if (f >= svm_pkg::NUM_REGS || s >= svm_pkg::NUM_REGS) r.st = svm_pkg::ST_BADREG;
          else regs[s] = regs[f];
        end
        svm_pkg::OP_SET: begin
          words = 2;
          if (f >= svm_pkg::NUM_REGS) r.st = svm_pkg::ST_BADREG;
          else regs[f] = s;
        end
        svm_pkg::OP_LOG: begin
          words = 1;
          if (f >= svm_pkg::NUM_REGS) r.st = svm_pkg::ST_BADREG;
          else begin
            r.value = regs[f];
            r.kind = svm_pkg::KIND_LOG;
          end
        end
        svm_pkg::OP_NOP: ;
        default: r.st = svm_pkg::ST_BADOP;
      endcase
      regs[svm_pkg::REG_IP] = regs[svm_pkg::REG_IP] + words + 1;
      r.hlt = stopped;
      r.ip = regs[svm_pkg::REG_IP];
      pending.push_back(r);
    endfunction

    // compare one accepted result with the oldest expectation
    function void check_result(vm_result_t got);
      vm_result_t e;
      if (pending.size() == 0) begin
        $error("unexpected result value %0d", got.value);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.value !== e.value) begin
        $error("result_value exp %0d got %0d", e.value, got.value); errors++;
      end
      if (got.kind !== e.kind) begin
        $error("result_kind exp %0d got %0d", e.kind, got.kind); errors++;
      end
      if (got.hlt !== e.hlt) begin
        $error("halted exp %0d got %0d", e.hlt, got.hlt); errors++;
      end
      if (got.ip !== e.ip) begin
        $error("next_ip exp %0d got %0d", e.ip, got.ip); errors++;
      end
      if (got.st !== e.st) begin
        $error("status exp %0d got %0d", e.st, got.st); errors++;
      end
    endfunction
  endclass

  logic clk, rst, in_valid, in_ready, out_valid, out_ready;
  logic [3:0] operation;
  logic signed [31:0] first_operand, second_operand, result_value, next_ip;
  logic [1:0] result_kind;
  logic halted;
  logic [2:0] status;

  vm_scoreboard board;
  bit quiet_tail;
  bit long_hold;
  longint cycles;

  stack_register_vm_execute dut (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // send one instruction request and wait for its acceptance
  task automatic send_instr(logic [3:0] op, logic [31:0] f, logic [31:0] s);
    int gap;
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    operation <= op;
    first_operand <= f;
    second_operand <= s;
    do @(posedge clk); while (!in_ready);
    board.note_request(op, f, s);
    in_valid <= 0;
    // the block stays busy after an accept
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 0;
      3: return $urandom_range(0, 20) - 10;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_reg();
    return ($urandom_range(0, 9) == 0) ? rand_word() : $urandom_range(0, 11);
  endfunction

  // random instruction mostly well formed, keeping the stack busy
  task automatic random_instr();
    int pick;
    logic [3:0] op;
    logic [31:0] s;
    pick = $urandom_range(0, 99);
    if (pick < 30) op = svm_pkg::OP_PSH;
    else if (pick < 38) op = svm_pkg::OP_POP;
    else if (pick < 68) op = 4'($urandom_range(svm_pkg::OP_ADD, svm_pkg::OP_SUB));
    else if (pick < 76) op = svm_pkg::OP_MOV;
    else if (pick < 84) op = svm_pkg::OP_SET;
    else if (pick < 94) op = svm_pkg::OP_LOG;
    else if (pick < 97) op = svm_pkg::OP_NOP;
    else op = 4'($urandom_range(11, 15));
    s = (op == svm_pkg::OP_SET) ? rand_word() : rand_reg();
    // keep stack pointer writes sane most of the time
    if (op == svm_pkg::OP_SET && $urandom_range(0, 3) != 0) s = $urandom_range(0, 40) - 1;
    send_instr(op, (op == svm_pkg::OP_PSH) ? rand_word() : rand_reg(), s);
  endtask

  // result side: random stalls, one long hold-off
  initial begin
    int hold;
    out_ready = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_ready <= 0;
        repeat (300) @(posedge clk);
        long_hold = 0;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        out_ready <= 0;
        hold = $urandom_range(1, 12);
        repeat (hold - 1) @(posedge clk);
      end else out_ready <= 1;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      board.check_result('{result_value, result_kind, halted, next_ip, status});
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    board = new();
    board.clear();
    quiet_tail = 0;
    long_hold = 0;
    rst = 1;
    in_valid = 0;
    operation = svm_pkg::OP_NOP;
    first_operand = 0;
    second_operand = 0;
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: underflows, extremes, div cases, bad regs and ops
    send_instr(svm_pkg::OP_POP, 0, 0);
    send_instr(svm_pkg::OP_ADD, 0, 0);
    send_instr(svm_pkg::OP_PSH, 32'h8000_0000, 0);
    send_instr(svm_pkg::OP_PSH, 32'hffff_ffff, 0);
    send_instr(svm_pkg::OP_DIV, 0, 0);
    send_instr(svm_pkg::OP_PSH, 0, 0);
    send_instr(svm_pkg::OP_DIV, 0, 0);
    send_instr(svm_pkg::OP_PSH, 32'h7fff_ffff, 0);
    send_instr(svm_pkg::OP_PSH, 32'h7fff_ffff, 0);
    send_instr(svm_pkg::OP_MUL, 0, 0);
    send_instr(svm_pkg::OP_PSH, -7, 0);
    send_instr(svm_pkg::OP_SUB, 0, 0);
    send_instr(svm_pkg::OP_LOG, 2, 0);
    send_instr(svm_pkg::OP_LOG, 32'hffff_ffff, 0);
    send_instr(svm_pkg::OP_MOV, 12, 0);
    send_instr(svm_pkg::OP_MOV, 0, 32'h8000_0000);
    send_instr(svm_pkg::OP_MOV, 2, 3);
    send_instr(svm_pkg::OP_SET, 10, 32'h7fff_fff0);
    send_instr(svm_pkg::OP_SET, 11, 32'h7fff_ffff);
    send_instr(svm_pkg::OP_PSH, 5, 0);
    send_instr(svm_pkg::OP_POP, 0, 0);
    send_instr(svm_pkg::OP_SET, 11, 32'hffff_fff0);
    send_instr(svm_pkg::OP_POP, 0, 0);
    send_instr(svm_pkg::OP_SET, 11, 254);
    send_instr(svm_pkg::OP_PSH, 1, 0);
    send_instr(svm_pkg::OP_PSH, 2, 0);
    send_instr(4'd15, 0, 0);

    // sender pauses until everything has drained
    wait_drained();
    long_hold = 1;
    for (int i = 0; i < 1100; i++) begin
      if (i == 1050) quiet_tail = 1;
      random_instr();
    end
    // halt then a few ignored requests
    send_instr(svm_pkg::OP_HLT, 0, 0);
    for (int i = 0; i < 4; i++) send_instr(4'($urandom_range(0, 15)), $urandom, $urandom);
    wait_drained();
    repeat (50) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
